@@ rtl/core/dcf_pkg.sv @@
// Shared types and constants of the densest cluster finder.
`timescale 1ns / 1ps
package dcf_pkg;
  localparam int COORD_W    = 24;
  localparam int TAG_W      = 32;
  localparam int MAG_W      = 24;
  localparam int HALF_W     = 12;
  localparam int PROD_W     = MAG_W + HALF_W;
  localparam int SQ_W       = 2 * MAG_W + 1;
  localparam int TH_W       = 32;
  localparam int SR_W       = 16;
  localparam int AR_W       = 15;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RANGE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AREA_RADIUS  = CFG_IDX_W'(1);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  localparam logic [SR_W-1:0] SEARCH_RANGE_RST = SR_W'(480);
  localparam logic [AR_W-1:0] AREA_RADIUS_RST  = AR_W'(80);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   start;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } dist_req_t;

  typedef struct packed {
    logic            done;
    logic [SQ_W-1:0] sum;
  } dist_rsp_t;
endpackage

@@ rtl/core/densest_cluster_finder.sv @@
// A new load beat is taken every cycle while no run is in progress.
// A run holds in_ready low through the threshold, range, count and emit passes, until
// the block returns to idle; every squared distance is computed in the shared
// multiplier unit. The emit pass sends the member beats and waits out any stalls.
// Reset clears the stored count, the overflow mark and the registers to 480 and 80.
`timescale 1ns / 1ps
module densest_cluster_finder import dcf_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic [TAG_W-1:0]      in_point_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TAG_W-1:0]      out_member_tag,
  output logic [SIZE_W-1:0]     out_cluster_size,
  output logic                  out_is_empty,
  output logic                  out_overflowed,
  output logic                  out_is_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int SW   = 5;

  localparam logic [SW-1:0] S_IDLE      = 5'd0;
  localparam logic [SW-1:0] S_TH_R_GO   = 5'd1;
  localparam logic [SW-1:0] S_TH_R_WAIT = 5'd2;
  localparam logic [SW-1:0] S_TH_C_GO   = 5'd3;
  localparam logic [SW-1:0] S_TH_C_WAIT = 5'd4;
  localparam logic [SW-1:0] S_M_RD      = 5'd5;
  localparam logic [SW-1:0] S_M_USE     = 5'd6;
  localparam logic [SW-1:0] S_M_WAIT    = 5'd7;
  localparam logic [SW-1:0] S_C_I_RD    = 5'd8;
  localparam logic [SW-1:0] S_C_I_USE   = 5'd9;
  localparam logic [SW-1:0] S_C_J_RD    = 5'd10;
  localparam logic [SW-1:0] S_C_J_USE   = 5'd11;
  localparam logic [SW-1:0] S_C_J_WAIT  = 5'd12;
  localparam logic [SW-1:0] S_E_I_RD    = 5'd13;
  localparam logic [SW-1:0] S_E_I_USE   = 5'd14;
  localparam logic [SW-1:0] S_E_J_RD    = 5'd15;
  localparam logic [SW-1:0] S_E_J_USE   = 5'd16;
  localparam logic [SW-1:0] S_E_J_WAIT  = 5'd17;
  localparam logic [SW-1:0] S_E_OUT     = 5'd18;
  localparam logic [SW-1:0] S_EMPTY     = 5'd19;

  logic [SW-1:0]     state_r, state_nxt;
  logic [CNTW-1:0]   pcount_r, pcount_nxt;
  logic              ovf_r, ovf_nxt;
  logic [SR_W-1:0]   sr_r, sr_nxt;
  logic [AR_W-1:0]   ar_r, ar_nxt;
  logic [TH_W-1:0]   range_sq_r, range_sq_nxt;
  logic [TH_W-1:0]   clus_sq_r, clus_sq_nxt;
  coord_t            ox_r, ox_nxt, oy_r, oy_nxt;
  coord_t            pix_r, pix_nxt, piy_r, piy_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt, best_cnt_r, best_cnt_nxt, k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [TAG_W-1:0]  out_tag_r, out_tag_nxt;
  logic [SIZE_W-1:0] out_size_r, out_size_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_last_r, out_last_nxt;

  logic                   pt_we;
  logic [2*COORD_W-1:0]   pt_rdata;
  logic [TAG_W-1:0]       tag_rdata;
  logic                   mask_we, mask_wdata;
  logic [0:0]             mask_rdata;
  coord_t                 px_rd, py_rd;
  dist_req_t              dreq;
  dist_rsp_t              drsp;
  logic                   hit, in_range, i_last, j_last;
  logic                   c_adv_j, adv_i, e_adv_j, go_empty;
  logic [CNTW-1:0]        cnt_fin;

  dcf_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pcount_r[AW-1:0]),
    .wdata ({in_pos_x, in_pos_y}),
    .raddr (addr_r),
    .rdata (pt_rdata)
  );

  dcf_ram #(.WIDTH(TAG_W), .DEPTH(MAX_POINTS)) u_tag_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pcount_r[AW-1:0]),
    .wdata (in_point_tag),
    .raddr (addr_r),
    .rdata (tag_rdata)
  );

  dcf_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (i_r),
    .wdata (mask_wdata),
    .raddr (addr_r),
    .rdata (mask_rdata)
  );

  dcf_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign px_rd    = pt_rdata[2*COORD_W-1:COORD_W];
  assign py_rd    = pt_rdata[COORD_W-1:0];
  assign hit      = drsp.sum <= SQ_W'(clus_sq_r);
  assign in_range = drsp.sum <= SQ_W'(range_sq_r);
  assign i_last   = (CNTW'(i_r) + CNTW'(1)) == pcount_r;
  assign j_last   = (CNTW'(j_r) + CNTW'(1)) == pcount_r;

  always_comb begin
    state_nxt     = state_r;
    pcount_nxt    = pcount_r;
    ovf_nxt       = ovf_r;
    sr_nxt        = sr_r;
    ar_nxt        = ar_r;
    range_sq_nxt  = range_sq_r;
    clus_sq_nxt   = clus_sq_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    pix_nxt       = pix_r;
    piy_nxt       = piy_r;
    addr_nxt      = addr_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    best_idx_nxt  = best_idx_r;
    cnt_nxt       = cnt_r;
    best_cnt_nxt  = best_cnt_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_tag_nxt   = out_tag_r;
    out_size_nxt  = out_size_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    pt_we         = 1'b0;
    mask_we       = 1'b0;
    mask_wdata    = in_range;
    dreq          = '0;
    c_adv_j       = 1'b0;
    adv_i         = 1'b0;
    e_adv_j       = 1'b0;
    go_empty      = 1'b0;
    cnt_fin       = cnt_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_SEARCH_RANGE: sr_nxt = cfg_data;
        REG_AREA_RADIUS:  ar_nxt = cfg_data[AR_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            if (pcount_r < CNTW'(MAX_POINTS)) begin
              pt_we      = 1'b1;
              pcount_nxt = pcount_r + CNTW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            ox_nxt    = in_pos_x;
            oy_nxt    = in_pos_y;
            state_nxt = S_TH_R_GO;
          end
        end
      end
      S_TH_R_GO: begin
        dreq.start = 1'b1;
        dreq.ax    = {{(COORD_W-SR_W){1'b0}}, sr_r};
        state_nxt  = S_TH_R_WAIT;
      end
      S_TH_R_WAIT: begin
        if (drsp.done) begin
          range_sq_nxt = drsp.sum[TH_W-1:0];
          state_nxt    = S_TH_C_GO;
        end
      end
      S_TH_C_GO: begin
        dreq.start = 1'b1;
        dreq.ax    = {{(COORD_W-AR_W-1){1'b0}}, ar_r, 1'b0};
        state_nxt  = S_TH_C_WAIT;
      end
      S_TH_C_WAIT: begin
        if (drsp.done) begin
          clus_sq_nxt = drsp.sum[TH_W-1:0];
          if (pcount_r == '0) begin
            go_empty = 1'b1;
          end else begin
            i_nxt     = '0;
            addr_nxt  = '0;
            state_nxt = S_M_RD;
          end
        end
      end
      S_M_RD: state_nxt = S_M_USE;
      S_M_USE: begin
        dreq.start = 1'b1;
        dreq.ax    = px_rd;
        dreq.ay    = py_rd;
        dreq.bx    = ox_r;
        dreq.by    = oy_r;
        state_nxt  = S_M_WAIT;
      end
      S_M_WAIT: begin
        if (drsp.done) begin
          mask_we = 1'b1;
          if (i_last) begin
            i_nxt        = '0;
            addr_nxt     = '0;
            best_cnt_nxt = '0;
            best_idx_nxt = '0;
            state_nxt    = S_C_I_RD;
          end else begin
            i_nxt     = i_r + AW'(1);
            addr_nxt  = i_r + AW'(1);
            state_nxt = S_M_RD;
          end
        end
      end
      S_C_I_RD: state_nxt = S_C_I_USE;
      S_C_I_USE: begin
        if (mask_rdata[0]) begin
          pix_nxt   = px_rd;
          piy_nxt   = py_rd;
          cnt_nxt   = '0;
          j_nxt     = '0;
          addr_nxt  = '0;
          state_nxt = S_C_J_RD;
        end else begin
          adv_i = 1'b1;
        end
      end
      S_C_J_RD: state_nxt = S_C_J_USE;
      S_C_J_USE: begin
        if (mask_rdata[0]) begin
          dreq.start = 1'b1;
          dreq.ax    = pix_r;
          dreq.ay    = piy_r;
          dreq.bx    = px_rd;
          dreq.by    = py_rd;
          state_nxt  = S_C_J_WAIT;
        end else begin
          c_adv_j = 1'b1;
        end
      end
      S_C_J_WAIT: begin
        if (drsp.done) begin
          cnt_fin = hit ? cnt_r + CNTW'(1) : cnt_r;
          c_adv_j = 1'b1;
        end
      end
      S_E_I_RD: state_nxt = S_E_I_USE;
      S_E_I_USE: begin
        pix_nxt   = px_rd;
        piy_nxt   = py_rd;
        j_nxt     = '0;
        k_nxt     = '0;
        addr_nxt  = '0;
        state_nxt = S_E_J_RD;
      end
      S_E_J_RD: state_nxt = S_E_J_USE;
      S_E_J_USE: begin
        if (mask_rdata[0]) begin
          dreq.start = 1'b1;
          dreq.ax    = pix_r;
          dreq.ay    = piy_r;
          dreq.bx    = px_rd;
          dreq.by    = py_rd;
          state_nxt  = S_E_J_WAIT;
        end else begin
          e_adv_j = 1'b1;
        end
      end
      S_E_J_WAIT: begin
        if (drsp.done) begin
          if (hit) begin
            out_valid_nxt = 1'b1;
            out_tag_nxt   = tag_rdata;
            out_size_nxt  = SIZE_W'(best_cnt_r);
            out_empty_nxt = 1'b0;
            out_last_nxt  = (k_r + CNTW'(1)) == best_cnt_r;
            state_nxt     = S_E_OUT;
          end else begin
            e_adv_j = 1'b1;
          end
        end
      end
      S_E_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_r + CNTW'(1);
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            e_adv_j = 1'b1;
          end
        end
      end
      S_EMPTY: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (c_adv_j) begin
      cnt_nxt = cnt_fin;
      if (j_last) begin
        if (cnt_fin > best_cnt_r) begin
          best_cnt_nxt = cnt_fin;
          best_idx_nxt = i_r;
        end
        adv_i = 1'b1;
      end else begin
        j_nxt     = j_r + AW'(1);
        addr_nxt  = j_r + AW'(1);
        state_nxt = S_C_J_RD;
      end
    end

    if (adv_i) begin
      if (i_last) begin
        if (best_cnt_nxt == '0) begin
          go_empty = 1'b1;
        end else begin
          addr_nxt  = best_idx_nxt;
          state_nxt = S_E_I_RD;
        end
      end else begin
        i_nxt     = i_r + AW'(1);
        addr_nxt  = i_r + AW'(1);
        state_nxt = S_C_I_RD;
      end
    end

    if (e_adv_j) begin
      if (j_last) begin
        state_nxt = S_IDLE;
      end else begin
        j_nxt     = j_r + AW'(1);
        addr_nxt  = j_r + AW'(1);
        state_nxt = S_E_J_RD;
      end
    end

    if (go_empty) begin
      out_valid_nxt = 1'b1;
      out_tag_nxt   = '0;
      out_size_nxt  = '0;
      out_empty_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      state_nxt     = S_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pcount_r    <= '0;
      ovf_r       <= 1'b0;
      sr_r        <= SEARCH_RANGE_RST;
      ar_r        <= AREA_RADIUS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pcount_r    <= pcount_nxt;
      ovf_r       <= ovf_nxt;
      sr_r        <= sr_nxt;
      ar_r        <= ar_nxt;
      out_valid_r <= out_valid_nxt;
    end
    range_sq_r  <= range_sq_nxt;
    clus_sq_r   <= clus_sq_nxt;
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    pix_r       <= pix_nxt;
    piy_r       <= piy_nxt;
    addr_r      <= addr_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    best_idx_r  <= best_idx_nxt;
    cnt_r       <= cnt_nxt;
    best_cnt_r  <= best_cnt_nxt;
    k_r         <= k_nxt;
    out_tag_r   <= out_tag_nxt;
    out_size_r  <= out_size_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_member_tag   = out_tag_r;
  assign out_cluster_size = out_size_r;
  assign out_is_empty     = out_empty_r;
  assign out_overflowed   = ovf_r;
  assign out_is_last      = out_last_r;
endmodule

@@ rtl/core/dcf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module dcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/dcf_dist.sv @@
// Squared distance unit built around one shared 24 by 12 bit multiplier.
`timescale 1ns / 1ps
module dcf_dist import dcf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dist_req_t req,
  output dist_rsp_t rsp
);
  localparam logic [2:0] PH_MUL_LAST = 3'd3;
  localparam logic [2:0] PH_ACC_LAST = 3'd4;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [2:0]        ph_r, ph_nxt;
  logic [MAG_W-1:0]  mag_x_r, mag_x_nxt;
  logic [MAG_W-1:0]  mag_y_r, mag_y_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              sh_r, sh_nxt;
  logic [SQ_W-1:0]   acc_r, acc_nxt;

  logic signed [COORD_W:0] dx, dy;
  logic [MAG_W-1:0]        opnd;
  logic [HALF_W-1:0]       part;
  logic [SQ_W-1:0]         shifted;

  always_comb begin
    dx = {req.ax[COORD_W-1], req.ax} - {req.bx[COORD_W-1], req.bx};
    dy = {req.ay[COORD_W-1], req.ay} - {req.by[COORD_W-1], req.by};
    opnd = ph_r[1] ? mag_y_r : mag_x_r;
    part = ph_r[0] ? opnd[MAG_W-1:HALF_W] : opnd[HALF_W-1:0];
    shifted = sh_r ? SQ_W'({prod_r, {HALF_W{1'b0}}}) : SQ_W'(prod_r);

    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    ph_nxt    = ph_r;
    mag_x_nxt = mag_x_r;
    mag_y_nxt = mag_y_r;
    prod_nxt  = prod_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;

    if (busy_r) begin
      if (ph_r <= PH_MUL_LAST) begin
        prod_nxt = PROD_W'(opnd) * PROD_W'(part);
        sh_nxt   = ph_r[0];
      end
      if (ph_r != 3'd0) begin
        acc_nxt = acc_r + shifted;
      end
      if (ph_r == PH_ACC_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      ph_nxt = ph_r + 3'd1;
    end else if (req.start) begin
      mag_x_nxt = dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
      mag_y_nxt = dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
      acc_nxt   = '0;
      ph_nxt    = 3'd0;
      busy_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
    end
    mag_x_r <= mag_x_nxt;
    mag_y_r <= mag_y_nxt;
    prod_r  <= prod_nxt;
    sh_r    <= sh_nxt;
    acc_r   <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.sum  = acc_r;
endmodule
